FILE: sv/jsect_pkg.sv
// Shared widths and constants for the job-shop earliest-completion dispatcher.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps

package jsect_pkg;

  localparam int DUR_W   = 16;
  localparam int WT_W    = 16;
  localparam int TIME_W  = 22;
  localparam int CFG_W   = 4;
  localparam int ID_W    = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int RESULT_CAP = 64;
  localparam int RCNT_W     = $clog2(RESULT_CAP + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_JOBS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MACHINES = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET_COUNT = 4'd8;

endpackage

FILE: sv/jsect_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instanced by the dispatcher for its operation stores.
`timescale 1ns / 1ps

module jsect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/job_shop_ect_dispatcher.sv
// Job-shop dispatcher. Loads one item per cycle while idle (in_ready high when idle).
// On an item marked last_item the block schedules in rounds: each round issues nj
// operation-store reads into a three-step compare pipeline, lets it drain, then commits;
// one round runs per loaded operation of the first nj jobs, plus a final empty round.
// Counting then sums the list lengths; emission reads and puts each result, steps past
// each job and may stall on the output. Synchronous reset empties all lists, counts 8.
`timescale 1ns / 1ps

module job_shop_ect_dispatcher
  import jsect_pkg::*;
#(
  parameter int MAX_JOBS        = 8,
  parameter int MAX_MACHINES    = 8,
  parameter int MAX_OPS_PER_JOB = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ID_W-1:0]      job_id,
  input  logic [ID_W-1:0]      machine_id,
  input  logic [DUR_W-1:0]     duration,
  input  logic [WT_W-1:0]      job_weight,
  input  logic                 last_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ID_W-1:0]      out_job,
  output logic [ID_W-1:0]      out_op_index,
  output logic [TIME_W-1:0]    start_time,
  output logic                 last_result
);

  localparam int JW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int JCW   = $clog2(MAX_JOBS + 1);
  localparam int MW    = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int MCW   = $clog2(MAX_MACHINES + 1);
  localparam int OW    = (MAX_OPS_PER_JOB > 1) ? $clog2(MAX_OPS_PER_JOB) : 1;
  localparam int CW    = $clog2(MAX_OPS_PER_JOB + 1);
  localparam int TOT_W = $clog2(MAX_JOBS * MAX_OPS_PER_JOB + 1);
  localparam int DEPTH = MAX_JOBS * (1 << OW);
  localparam int OP_W  = MW + DUR_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_COUNT  = 3'd3;
  localparam logic [2:0] S_EMRD   = 3'd4;
  localparam logic [2:0] S_EMPUT  = 3'd5;

  logic [2:0] state;

  logic [CFG_W-1:0] jobs_cfg;
  logic [CFG_W-1:0] machines_cfg;
  logic [JCW-1:0]   nj;
  logic [MCW-1:0]   mlim;

  logic [CW-1:0]     ops_count  [MAX_JOBS];
  logic [CW-1:0]     next_op    [MAX_JOBS];
  logic [WT_W-1:0]   weight     [MAX_JOBS];
  logic [TIME_W-1:0] job_ready  [MAX_JOBS];
  logic [TIME_W-1:0] mach_free  [MAX_MACHINES];

  // Scan pipeline: issue, then start time, then finish and compare.
  logic [JCW-1:0]    issue_j;
  logic              p1_valid;
  logic [JW-1:0]     p1_j;
  logic              p2_valid;
  logic [JW-1:0]     p2_j;
  logic [TIME_W-1:0] p2_st;
  logic [DUR_W-1:0]  p2_dur;
  logic [MW-1:0]     p2_mach;

  logic              found;
  logic [JW-1:0]     best_j;
  logic [TIME_W-1:0] best_fin;
  logic [TIME_W-1:0] best_st;
  logic [WT_W-1:0]   best_w;
  logic [MW-1:0]     best_mach;

  logic [JCW-1:0]    ej;
  logic [CW-1:0]     ek;
  logic [TOT_W-1:0]  total;
  logic [RCNT_W-1:0] lim;
  logic [RCNT_W-1:0] n_out;

  logic              in_fire;
  logic [JW-1:0]     ld_j;
  logic [CW-1:0]     ld_k;
  logic              ld_ok;
  logic              issue_go;
  logic              issue_has;
  logic [JW-1:0]     ij;
  logic [JW-1:0]     ejx;
  logic              out_free;

  logic              op_we;
  logic [$clog2(DEPTH)-1:0] op_waddr;
  logic [$clog2(DEPTH)-1:0] op_raddr;
  logic [OP_W-1:0]   op_rdata;
  logic [MW-1:0]     rd_mach;
  logic [DUR_W-1:0]  rd_dur;

  logic              st_we;
  logic [$clog2(DEPTH)-1:0] st_waddr;
  logic [$clog2(DEPTH)-1:0] st_raddr;
  logic [TIME_W-1:0] st_rdata;

  logic [TIME_W-1:0] a_jr;
  logic [TIME_W-1:0] a_mf;
  logic [TIME_W-1:0] a_st;
  logic [TIME_W:0]   b_sum;
  logic [TIME_W-1:0] b_fin;
  logic [WT_W-1:0]   b_w;
  logic              b_better;

  always_comb begin
    if (jobs_cfg == '0) begin
      nj = JCW'(1);
    end else if (32'(jobs_cfg) > MAX_JOBS) begin
      nj = JCW'(MAX_JOBS);
    end else begin
      nj = JCW'(jobs_cfg);
    end
    if (machines_cfg == '0) begin
      mlim = MCW'(1);
    end else if (32'(machines_cfg) > MAX_MACHINES) begin
      mlim = MCW'(MAX_MACHINES);
    end else begin
      mlim = MCW'(machines_cfg);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Loading: append to the job's list when job, machine and capacity allow.
  assign ld_j  = JW'(job_id);
  assign ld_k  = ops_count[ld_j];
  assign ld_ok = (32'(job_id) < MAX_JOBS) && (32'(machine_id) < 32'(mlim)) &&
                 (32'(ld_k) < MAX_OPS_PER_JOB);

  assign op_we    = in_fire && ld_ok;
  assign op_waddr = {ld_j, ld_k[OW-1:0]};

  assign ij        = issue_j[JW-1:0];
  assign issue_go  = (state == S_SCAN) && (issue_j < nj);
  assign issue_has = next_op[ij] < ops_count[ij];
  assign op_raddr  = {ij, next_op[ij][OW-1:0]};

  jsect_ram #(.WIDTH(OP_W), .DEPTH(DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (op_waddr),
    .wdata ({MW'(machine_id), duration}),
    .raddr (op_raddr),
    .rdata (op_rdata)
  );

  assign rd_mach = op_rdata[OP_W-1:DUR_W];
  assign rd_dur  = op_rdata[DUR_W-1:0];

  assign ejx      = ej[JW-1:0];
  assign st_we    = (state == S_COMMIT);
  assign st_waddr = {best_j, next_op[best_j][OW-1:0]};
  assign st_raddr = {ejx, ek[OW-1:0]};

  jsect_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (best_st),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Start is the later of job-ready and machine-free.
  assign a_jr = job_ready[p1_j];
  assign a_mf = mach_free[rd_mach];
  assign a_st = (a_jr > a_mf) ? a_jr : a_mf;

  // Finish saturates at the top of the time range.
  assign b_sum    = {1'b0, p2_st} + {{(TIME_W + 1 - DUR_W){1'b0}}, p2_dur};
  assign b_fin    = b_sum[TIME_W] ? TIME_MAX : b_sum[TIME_W-1:0];
  assign b_w      = weight[p2_j];
  assign b_better = !found || (b_fin < best_fin) || ((b_fin == best_fin) && (b_w > best_w));

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      jobs_cfg     <= CFG_RESET_COUNT;
      machines_cfg <= CFG_RESET_COUNT;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
      issue_j      <= '0;
      ej           <= '0;
      ek           <= '0;
      n_out        <= '0;
      total        <= '0;
      for (int j = 0; j < MAX_JOBS; j++) begin
        ops_count[j] <= '0;
        next_op[j]   <= '0;
        job_ready[j] <= '0;
      end
      for (int m = 0; m < MAX_MACHINES; m++) begin
        mach_free[m] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_JOBS) begin
          jobs_cfg <= cfg_data;
        end else if (cfg_index == CFG_MACHINES) begin
          machines_cfg <= cfg_data;
        end
      end

      // In S_EMPUT the output register is reloaded below instead.
      if (out_valid && out_ready && (state != S_EMPUT)) begin
        out_valid <= 1'b0;
      end

      p1_valid <= issue_go && issue_has;
      p2_valid <= p1_valid;

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (ld_ok) begin
              ops_count[ld_j] <= ld_k + CW'(1);
            end
            if (last_item) begin
              issue_j <= '0;
              found   <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue_go) begin
            issue_j <= issue_j + JCW'(1);
          end
          if (p2_valid && b_better) begin
            found <= 1'b1;
          end
          if (!issue_go && !p1_valid && !p2_valid) begin
            if (found) begin
              state <= S_COMMIT;
            end else begin
              ej    <= '0;
              total <= '0;
              state <= S_COUNT;
            end
          end
        end
        S_COMMIT: begin
          job_ready[best_j] <= best_fin;
          mach_free[best_mach] <= best_fin;
          next_op[best_j] <= next_op[best_j] + CW'(1);
          issue_j <= '0;
          found   <= 1'b0;
          state   <= S_SCAN;
        end
        S_COUNT: begin
          if (ej < nj) begin
            total <= total + TOT_W'(ops_count[ejx]);
            ej    <= ej + JCW'(1);
          end else begin
            ej    <= '0;
            ek    <= '0;
            n_out <= '0;
            state <= S_EMRD;
          end
        end
        S_EMRD: begin
          // A result remains as long as the count is short of the limit.
          if (n_out == lim) begin
            for (int j = 0; j < MAX_JOBS; j++) begin
              ops_count[j] <= '0;
              next_op[j]   <= '0;
              job_ready[j] <= '0;
            end
            for (int m = 0; m < MAX_MACHINES; m++) begin
              mach_free[m] <= '0;
            end
            state <= S_IDLE;
          end else if (ek >= ops_count[ejx]) begin
            ej <= ej + JCW'(1);
            ek <= '0;
          end else begin
            state <= S_EMPUT;
          end
        end
        S_EMPUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            n_out     <= n_out + RCNT_W'(1);
            ek        <= ek + CW'(1);
            state     <= S_EMRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (op_we && (ld_k == '0)) begin
      weight[ld_j] <= job_weight;
    end
    p1_j    <= ij;
    p2_j    <= p1_j;
    p2_st   <= a_st;
    p2_dur  <= rd_dur;
    p2_mach <= rd_mach;
    if (state == S_SCAN && p2_valid && b_better) begin
      best_j    <= p2_j;
      best_fin  <= b_fin;
      best_st   <= p2_st;
      best_w    <= b_w;
      best_mach <= p2_mach;
    end
    if (state == S_COUNT && !(ej < nj)) begin
      lim <= (32'(total) > RESULT_CAP) ? RCNT_W'(RESULT_CAP) : RCNT_W'(total);
    end
    if (state == S_EMPUT && out_free) begin
      out_job      <= ID_W'(ej);
      out_op_index <= ID_W'(ek);
      start_time   <= st_rdata;
      last_result  <= (n_out + RCNT_W'(1)) == lim;
    end
  end

endmodule

FILE: sv/jsect_checker.sv
// Port-level checker for the job-shop dispatcher, bound to its top level.
// Depends on jsect_pkg and on the port names of job_shop_ect_dispatcher.
`timescale 1ns / 1ps

module jsect_checker
  import jsect_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 last_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ID_W-1:0]      out_job,
  input logic [ID_W-1:0]      out_op_index,
  input logic [TIME_W-1:0]    start_time,
  input logic                 last_result
);

  // Coming out of reset the block is empty and ready for an item.
  a_reset_state: assert property (@(posedge clk) rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // A final item starts scheduling, so loading stops at once.
  a_sched_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_item) |=> !in_ready)
    else $error("ready stayed high after the final item");

  // Once the marked result is taken nothing of that schedule follows it.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> !out_valid)
    else $error("result offered right after the final one");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_job) && $stable(out_op_index) &&
       $stable(start_time) && $stable(last_result)))
    else $error("stalled result changed");

endmodule

bind job_shop_ect_dispatcher jsect_checker u_jsect_checker (.*);

FILE: sim/tb_job_shop_ect_dispatcher.sv
// Self-checking testbench for the job-shop earliest-completion dispatcher.
// Loads random and directed problems, predicts every start time internally, and
// checks each result item in order. Depends on jsect_pkg and the dispatcher top.
`timescale 1ns / 1ps

module tb_job_shop_ect_dispatcher;
  import jsect_pkg::*;

  localparam int NJOB          = 8;
  localparam int NMACH         = 8;
  localparam int NOPS          = 8;
  localparam int SETTLE_CYCLES = 1000;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 244;

  typedef struct packed {
    logic [ID_W-1:0]   job;
    logic [ID_W-1:0]   op;
    logic [TIME_W-1:0] start;
    logic              last;
  } start_rec_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [ID_W-1:0]      job_id;
  logic [ID_W-1:0]      machine_id;
  logic [DUR_W-1:0]     duration;
  logic [WT_W-1:0]      job_weight;
  logic                 last_item;
  logic                 out_valid;
  logic                 out_ready;
  logic [ID_W-1:0]      out_job;
  logic [ID_W-1:0]      out_op_index;
  logic [TIME_W-1:0]    start_time;
  logic                 last_result;

  // Model of the block's loaded problem and registers.
  logic [ID_W-1:0]  ld_mach [NJOB][NOPS];
  logic [DUR_W-1:0] ld_dur  [NJOB][NOPS];
  int               ld_cnt  [NJOB];
  logic [WT_W-1:0]  ld_wt   [NJOB];
  logic [CFG_W-1:0] jobs_reg;
  logic [CFG_W-1:0] machs_reg;

  start_rec_t start_q[$];
  start_rec_t exp_rec;

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  schedules_run = 0;
  int  starts_seen   = 0;
  int  idle_cycles   = 0;
  bit  no_gaps       = 1'b0;
  bit  fast_drain    = 1'b0;

  job_shop_ect_dispatcher u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .job_id       (job_id),
    .machine_id   (machine_id),
    .duration     (duration),
    .job_weight   (job_weight),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_job      (out_job),
    .out_op_index (out_op_index),
    .start_time   (start_time),
    .last_result  (last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_count(logic [CFG_W-1:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [TIME_W-1:0] sat_finish(logic [TIME_W-1:0] st,
                                                   logic [DUR_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, st} + d;
    return (s > TIME_MAX) ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Appends one operation to its job; on the last item runs the greedy schedule
  // and queues every start time in job-major order.
  task automatic load_and_dispatch(input logic [ID_W-1:0] j, input logic [ID_W-1:0] m,
                                   input logic [DUR_W-1:0] d, input logic [WT_W-1:0] w,
                                   input logic l);
    int               nj, k, n, total, best_j, mi;
    int               next_op [NJOB];
    logic [TIME_W-1:0] ready  [NJOB];
    logic [TIME_W-1:0] mfree  [NMACH];
    logic [TIME_W-1:0] starts [NJOB][NOPS];
    logic [TIME_W-1:0] st, fin, best_fin;
    logic [WT_W-1:0]   best_w;
    bit                found;
    start_rec_t        rec;
    if (m < clamp_count(machs_reg, NMACH) && ld_cnt[j] < NOPS) begin
      if (ld_cnt[j] == 0) ld_wt[j] = w;
      ld_mach[j][ld_cnt[j]] = m;
      ld_dur[j][ld_cnt[j]] = d;
      ld_cnt[j]++;
    end
    if (!l) return;
    schedules_run++;
    nj = clamp_count(jobs_reg, NJOB);
    for (int i = 0; i < NJOB; i++) begin
      next_op[i] = 0;
      ready[i] = '0;
    end
    for (int i = 0; i < NMACH; i++) mfree[i] = '0;
    best_j = 0;
    best_fin = '0;
    best_w = '0;
    while (1) begin
      found = 1'b0;
      for (int jj = 0; jj < nj; jj++) begin
        k = next_op[jj];
        if (k >= ld_cnt[jj]) continue;
        mi = ld_mach[jj][k];
        st = (ready[jj] > mfree[mi]) ? ready[jj] : mfree[mi];
        fin = sat_finish(st, ld_dur[jj][k]);
        if (!found || fin < best_fin || (fin == best_fin && ld_wt[jj] > best_w)) begin
          found = 1'b1;
          best_j = jj;
          best_fin = fin;
          best_w = ld_wt[jj];
        end
      end
      if (!found) break;
      k = next_op[best_j];
      mi = ld_mach[best_j][k];
      st = (ready[best_j] > mfree[mi]) ? ready[best_j] : mfree[mi];
      fin = sat_finish(st, ld_dur[best_j][k]);
      starts[best_j][k] = st;
      ready[best_j] = fin;
      mfree[mi] = fin;
      next_op[best_j] = k + 1;
    end
    total = 0;
    for (int jj = 0; jj < nj; jj++) total += ld_cnt[jj];
    if (total > RESULT_CAP) total = RESULT_CAP;
    n = 0;
    for (int jj = 0; jj < nj; jj++) begin
      for (int kk = 0; kk < ld_cnt[jj]; kk++) begin
        if (n < RESULT_CAP) begin
          rec.job = jj[ID_W-1:0];
          rec.op = kk[ID_W-1:0];
          rec.start = starts[jj][kk];
          rec.last = (n == total - 1);
          start_q.push_back(rec);
          n++;
        end
      end
    end
    // The block starts a fresh problem after every schedule.
    for (int i = 0; i < NJOB; i++) begin
      ld_cnt[i] = 0;
      ld_wt[i] = '0;
    end
  endtask

  task automatic send_op(input logic [ID_W-1:0] j, input logic [ID_W-1:0] m,
                         input logic [DUR_W-1:0] d, input logic [WT_W-1:0] w,
                         input logic l);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    job_id     <= j;
    machine_id <= m;
    duration   <= d;
    job_weight <= w;
    last_item  <= l;
    do @(posedge clk); while (!in_ready);
    load_and_dispatch(j, m, d, w, l);
    items_sent++;
  endtask

  // Waits until every start time is back, then lets a schedule that produced
  // nothing run out before the block is touched again.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (start_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_JOBS:     jobs_reg = val;
      CFG_MACHINES: machs_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2: return 4'd1;
      3: return 4'd8;
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic test_default_counts();
    send_op(3'd0, 3'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_op(3'd7, 3'd7, 16'h0000, 16'h0000, 1'b0);
    send_op(3'd0, 3'd7, 16'hFFFF, 16'h0001, 1'b0);
    send_op(3'd3, 3'd4, 16'h1234, 16'h8000, 1'b0);
    send_op(3'd7, 3'd0, 16'h0001, 16'h0000, 1'b1);
    drain_block();
  endtask

  task automatic test_tie_breaks();
    write_reg(CFG_JOBS, 4'd15);
    write_reg(CFG_MACHINES, 4'd8);
    // Equal finish on a shared machine: higher weight first, then lower job.
    send_op(3'd1, 3'd2, 16'd10, 16'd5, 1'b0);
    send_op(3'd2, 3'd2, 16'd10, 16'd9, 1'b0);
    send_op(3'd4, 3'd3, 16'd7, 16'd3, 1'b0);
    send_op(3'd5, 3'd3, 16'd7, 16'd3, 1'b0);
    send_op(3'd6, 3'd3, 16'd0, 16'd0, 1'b0);
    send_op(3'd1, 3'd3, 16'd0, 16'd0, 1'b1);
    drain_block();
  endtask

  task automatic test_drops();
    write_reg(CFG_MACHINES, 4'd3);
    // A dropped first item must not set the job's weight.
    send_op(3'd6, 3'd5, 16'd100, 16'd999, 1'b0);
    for (int i = 0; i < NOPS + 1; i++)
      send_op(3'd6, 3'($urandom_range(0, 2)), 16'($urandom_range(1, 50)),
              16'(i + 7), 1'b0);
    send_op(3'd0, 3'd2, 16'd25, 16'd1, 1'b1);
    drain_block();
  endtask

  task automatic test_unused_and_empty();
    write_reg(CFG_JOBS, 4'd0);
    write_reg(CFG_MACHINES, 4'd1);
    // Nothing loaded: the last item yields no result at all.
    send_op(3'd0, 3'd1, 16'd5, 16'd5, 1'b1);
    drain_block();
    write_reg(CFG_JOBS, 4'd2);
    write_reg(CFG_MACHINES, 4'd15);
    send_op(3'd5, 3'd6, 16'd50, 16'd1, 1'b0);
    send_op(3'd1, 3'd6, 16'd20, 16'd2, 1'b0);
    send_op(3'd0, 3'd6, 16'd30, 16'd3, 1'b1);
    drain_block();
  endtask

  task automatic test_random_problems();
    int nops, nj, mlim, sent, bad_odds;
    logic [ID_W-1:0]  j, m;
    logic [DUR_W-1:0] d;
    logic [WT_W-1:0]  w;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_block();
        write_reg(CFG_JOBS, pick_count());
        write_reg(CFG_MACHINES, pick_count());
      end
      no_gaps    = ($urandom_range(0, 4) == 0);
      fast_drain = ($urandom_range(0, 4) == 0);
      nops = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 12);
      // The final problem is cut short so the item total comes out at exactly RANDOM_ITEMS.
      if (nops > RANDOM_ITEMS - sent) nops = RANDOM_ITEMS - sent;
      // Most problems drop few items; a few are flooded with dropped items.
      bad_odds = ($urandom_range(0, 7) == 0) ? 2 : 10;
      nj = clamp_count(jobs_reg, NJOB);
      mlim = clamp_count(machs_reg, NMACH);
      for (int i = 0; i < nops; i++) begin
        j = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(0, nj - 1))
                                        : 3'($urandom_range(0, 7));
        if (mlim < NMACH && $urandom_range(1, bad_odds) == 1)
          m = 3'($urandom_range(mlim, 7));
        else
          m = 3'($urandom_range(0, mlim - 1));
        case ($urandom_range(0, 3))
          0: d = 16'($urandom_range(0, 15));
          1: d = 16'($urandom);
          2: d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: d = 16'($urandom_range(0, 1000));
        endcase
        w = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        send_op(j, m, d, w, i == nops - 1);
        sent++;
      end
    end
    no_gaps = 1'b0;
    fast_drain = 1'b0;
  endtask

  initial begin : result_sink
    int hold;
    forever begin
      hold = fast_drain ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      starts_seen++;
      if (start_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: job %0d op %0d start %0d last %0b",
                   out_job, out_op_index, start_time, last_result);
      end else begin
        exp_rec = start_q.pop_front();
        if (out_job !== exp_rec.job || out_op_index !== exp_rec.op ||
            start_time !== exp_rec.start || last_result !== exp_rec.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected job %0d op %0d start %0d last %0b, got %0d %0d %0d %0b",
                     exp_rec.job, exp_rec.op, exp_rec.start, exp_rec.last,
                     out_job, out_op_index, start_time, last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no item accepted for %0d cycles", STALL_LIMIT);
      $display("tb_job_shop_ect_dispatcher NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_JOBS;
    cfg_data   = '0;
    in_valid   = 1'b0;
    job_id     = '0;
    machine_id = '0;
    duration   = '0;
    job_weight = '0;
    last_item  = 1'b0;
    out_ready  = 1'b0;
    jobs_reg   = CFG_RESET_COUNT;
    machs_reg  = CFG_RESET_COUNT;
    for (int i = 0; i < NJOB; i++) begin
      ld_cnt[i] = 0;
      ld_wt[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_counts();
    test_tie_breaks();
    test_drops();
    test_unused_and_empty();
    test_random_problems();
    drain_block();

    $display("Sent %0d items over %0d schedules; checked %0d start times.",
             items_sent, schedules_run, starts_seen);
    $display("Job and machine counts swept from 0 to 15, with %0d mismatches.",
             mismatches);
    if (mismatches == 0 && start_q.size() == 0) begin
      $display("tb_job_shop_ect_dispatcher OK");
    end else begin
      $display("tb_job_shop_ect_dispatcher NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/jsect_pkg.sv
sv/jsect_ram.sv
sv/job_shop_ect_dispatcher.sv
sv/jsect_checker.sv
sim/tb_job_shop_ect_dispatcher.sv
